@@ sv/cch_pkg.sv @@
`default_nettype none
package cch_pkg;

	localparam int LEN_W  = 34;   // squared vector length
	localparam int DOT_W  = 35;   // signed dot product
	localparam int NUM_W  = 22;   // 511 * scatter energy
	localparam int DEN_W  = 27;   // absorber energy * total energy
	localparam int ROOT_W = 17;   // floor square root of a LEN_W value
	localparam int COS_W  = 18;   // signed q16 cosine
	localparam int ANG_W  = 12;   // angle in 1/16 degree

	localparam int COS_ONE = 65536;
	localparam logic [ANG_W-1:0] ANGLE_MAX = 12'd2880;
	localparam logic [ANG_W-1:0] THRESHOLD_RESET = 12'd80;

	// register map: one register, word index taken from paddr[2]
	localparam logic IDX_THRESHOLD = 1'b0;

	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;
	localparam int FRONT_LAT   = 3;
	localparam int BUSY_LEVEL  = QUEUE_DEPTH - FRONT_LAT;

	typedef struct packed {
		logic [LEN_W-1:0]        la;
		logic [LEN_W-1:0]        lb;
		logic signed [DOT_W-1:0] dot;
		logic [NUM_W-1:0]        num;
		logic [DEN_W-1:0]        den;
		logic                    kin_ok;
	} pair_t;

	// atan(2^-i) in degree * 65536, rounded
	function automatic logic [22:0] atan_lut(input logic [4:0] i);
		logic [22:0] r;
		case (i)
			5'd0:  r = 23'd2949120;
			5'd1:  r = 23'd1740967;
			5'd2:  r = 23'd919879;
			5'd3:  r = 23'd466945;
			5'd4:  r = 23'd234379;
			5'd5:  r = 23'd117305;
			5'd6:  r = 23'd58666;
			5'd7:  r = 23'd29335;
			5'd8:  r = 23'd14668;
			5'd9:  r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/cch_sqrt.sv @@
`default_nettype none
module cch_sqrt #(
	parameter int W = 34
) (
	input  wire logic           clk,
	input  wire logic [W-1:0]   rad,
	output logic      [W/2-1:0] root
);
	localparam int HW    = W / 2;
	localparam int REM_W = HW + 2;

	logic [REM_W-1:0] rem_s  [HW];
	logic [HW-1:0]    root_s [HW];
	logic [W-1:0]     rad_s  [HW];

	// one result bit per stage, two radicand bits consumed each step
	for (genvar k = 0; k < HW; k++) begin : g_step
		logic [REM_W-1:0] rem_p;
		logic [HW-1:0]    root_p;
		logic [W-1:0]     rad_p;
		logic [REM_W+1:0] r4;
		logic [REM_W+1:0] trial;
		logic             ge;
		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end
		assign r4    = {rem_p, rad_p[W-1 -: 2]};
		assign trial = (REM_W+2)'({root_p, 2'b01});
		assign ge    = r4 >= trial;
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? REM_W'(r4 - trial) : REM_W'(r4);
			root_s[k] <= {root_p[HW-2:0], ge};
			rad_s[k]  <= {rad_p[W-3:0], 2'b00};
		end
	end

	assign root = root_s[HW-1];

endmodule
`default_nettype wire

@@ sv/cch_div.sv @@
`default_nettype none
module cch_div #(
	parameter int NW = 50,
	parameter int DW = 34,
	parameter int QW = 19
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);
	// restoring division, one quotient bit per stage; needs num >> QW < den
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_p;
		logic [QW-1:0] quo_p;
		logic [QW-1:0] low_p;
		logic [DW-1:0] den_p;
		logic [DW:0]   r2;
		logic          ge;
		if (k == 0) begin : g_first
			assign rem_p = DW'(num[NW-1:QW]);
			assign quo_p = '0;
			assign low_p = num[QW-1:0];
			assign den_p = den;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
			assign low_p = low_s[k-1];
			assign den_p = den_s[k-1];
		end
		assign r2 = {rem_p, low_p[QW-1]};
		assign ge = r2 >= {1'b0, den_p};
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DW'(r2 - {1'b0, den_p}) : DW'(r2);
			quo_s[k] <= {quo_p[QW-2:0], ge};
			low_s[k] <= {low_p[QW-2:0], 1'b0};
			den_s[k] <= den_p;
		end
	end

	assign quo = quo_s[QW-1];

endmodule
`default_nettype wire

@@ sv/cch_acos.sv @@
`default_nettype none
module cch_acos import cch_pkg::*; #(
	parameter int STEPS = 16
) (
	input  wire logic                    clk,
	input  wire logic signed [COS_W-1:0] c,
	output logic             [ANG_W-1:0] angle
);
	localparam int XY_W = 20;
	localparam int Z_W  = 26;
	localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * 65536);

	logic [ROOT_W-1:0]       cabs;
	logic [LEN_W-1:0]        csq;
	logic [LEN_W-1:0]        rad_s1;
	logic signed [COS_W-1:0] c_s1;
	logic [ROOT_W-1:0]       sin_r;
	logic signed [COS_W-1:0] cd_q [ROOT_W];

	logic signed [XY_W-1:0] x_s [STEPS+1];
	logic signed [XY_W-1:0] y_s [STEPS+1];
	logic signed [Z_W-1:0]  z_s [STEPS+1];

	logic signed [Z_W-1:0]  zr;
	logic signed [Z_W-13:0] t;
	logic [ANG_W-1:0]       angle_q;

	assign cabs = c[COS_W-1] ? ROOT_W'(-c) : ROOT_W'(c);
	assign csq  = LEN_W'(cabs) * LEN_W'(cabs);

	always_ff @(posedge clk) begin
		rad_s1 <= (LEN_W'(1) << 32) - csq;
		c_s1   <= c;
		cd_q[0] <= c_s1;
		for (int i = 1; i < ROOT_W; i++) cd_q[i] <= cd_q[i-1];
	end

	cch_sqrt #(.W(LEN_W)) u_sqrt (
		.clk  (clk),
		.rad  (rad_s1),
		.root (sin_r)
	);

	// negative cosine: start from the vector turned by a quarter turn
	always_ff @(posedge clk) begin
		if (cd_q[ROOT_W-1] < 0) begin
			x_s[0] <= XY_W'(signed'({1'b0, sin_r}));
			y_s[0] <= XY_W'(-cd_q[ROOT_W-1]);
			z_s[0] <= Z_QUARTER;
		end else begin
			x_s[0] <= XY_W'(cd_q[ROOT_W-1]);
			y_s[0] <= XY_W'(signed'({1'b0, sin_r}));
			z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic signed [Z_W-1:0]  ang;
		assign dx  = y_s[k] >>> k;
		assign dy  = x_s[k] >>> k;
		assign ang = Z_W'(signed'({1'b0, atan_lut(5'(k))}));
		always_ff @(posedge clk) begin
			if (y_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] + dx;
				y_s[k+1] <= y_s[k] - dy;
				z_s[k+1] <= z_s[k] + ang;
			end else begin
				x_s[k+1] <= x_s[k] - dx;
				y_s[k+1] <= y_s[k] + dy;
				z_s[k+1] <= z_s[k] - ang;
			end
		end
	end

	assign zr = z_s[STEPS] + Z_W'(2048);
	assign t  = zr[Z_W-1:12];

	always_ff @(posedge clk) begin
		if (t < 0)
			angle_q <= '0;
		else if (t > (Z_W-12)'(ANGLE_MAX))
			angle_q <= ANGLE_MAX;
		else
			angle_q <= ANG_W'(t);
	end

	assign angle = angle_q;

endmodule
`default_nettype wire

@@ sv/cch_front.sv @@
`default_nettype none
module cch_front import cch_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic signed [15:0] scatter_x,
	input  wire logic signed [15:0] scatter_y,
	input  wire logic signed [15:0] scatter_z,
	input  wire logic        [12:0] scatter_energy,
	input  wire logic signed [15:0] absorber_x,
	input  wire logic signed [15:0] absorber_y,
	input  wire logic signed [15:0] absorber_z,
	input  wire logic        [12:0] absorber_energy,
	input  wire logic signed [15:0] voxel_x,
	input  wire logic signed [15:0] voxel_y,
	input  wire logic signed [15:0] voxel_z,
	output logic                    push,
	output pair_t                   item
);
	logic v_s1, v_s2, v_s3;

	logic signed [15:0] sc_s1 [3];
	logic signed [15:0] ab_s1 [3];
	logic signed [15:0] vx_s1 [3];
	logic [12:0]        e1_s1, e2_s1;

	logic signed [16:0] a [3];
	logic signed [16:0] b [3];
	logic signed [33:0] paa [3];
	logic signed [33:0] pbb [3];
	logic signed [33:0] pab [3];
	logic [13:0]        esum;

	logic [32:0]        aa_s2 [3];
	logic [32:0]        bb_s2 [3];
	logic signed [33:0] ab_s2 [3];
	logic [NUM_W-1:0]   num_s2;
	logic [DEN_W-1:0]   den_s2;
	logic               nz_s2;

	pair_t item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sc_s1[0] <= scatter_x;
			sc_s1[1] <= scatter_y;
			sc_s1[2] <= scatter_z;
			ab_s1[0] <= absorber_x;
			ab_s1[1] <= absorber_y;
			ab_s1[2] <= absorber_z;
			vx_s1[0] <= voxel_x;
			vx_s1[1] <= voxel_y;
			vx_s1[2] <= voxel_z;
			e1_s1    <= scatter_energy;
			e2_s1    <= absorber_energy;
		end
	end

	// a = scatter - voxel, b = absorber - scatter
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[k]   = 17'(sc_s1[k]) - 17'(vx_s1[k]);
			b[k]   = 17'(ab_s1[k]) - 17'(sc_s1[k]);
			paa[k] = 34'(a[k]) * 34'(a[k]);
			pbb[k] = 34'(b[k]) * 34'(b[k]);
			pab[k] = 34'(a[k]) * 34'(b[k]);
		end
		esum = 14'(e1_s1) + 14'(e2_s1);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			aa_s2[k] <= paa[k][32:0];
			bb_s2[k] <= pbb[k][32:0];
			ab_s2[k] <= pab[k];
		end
		num_s2 <= (NUM_W'(e1_s1) << 9) - NUM_W'(e1_s1);
		den_s2 <= DEN_W'(e2_s1) * DEN_W'(esum);
		nz_s2  <= (e1_s1 != '0) && (e2_s1 != '0);
	end

	always_ff @(posedge clk) begin
		item_s3.la     <= LEN_W'(aa_s2[0]) + LEN_W'(aa_s2[1]) + LEN_W'(aa_s2[2]);
		item_s3.lb     <= LEN_W'(bb_s2[0]) + LEN_W'(bb_s2[1]) + LEN_W'(bb_s2[2]);
		item_s3.dot    <= DOT_W'(ab_s2[0]) + DOT_W'(ab_s2[1]) + DOT_W'(ab_s2[2]);
		item_s3.num    <= num_s2;
		item_s3.den    <= den_s2;
		item_s3.kin_ok <= nz_s2 && ((DEN_W+1)'(num_s2) < {den_s2, 1'b0});
	end

	assign push = v_s3;
	assign item = item_s3;

endmodule
`default_nettype wire

@@ sv/cch_fifo.sv @@
`default_nettype none
module cch_fifo import cch_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire pair_t                 wdata,
	input  wire logic                  pop,
	output pair_t                      rdata,
	output logic                       rvalid,
	output logic                       empty,
	output logic [QUEUE_AW:0]          level
);
	pair_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_pop;
	pair_t               rdata_q;
	logic                rvalid_q;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
			rvalid_q <= do_pop;
		end
	end

	// registered read; a pop never targets the entry being written
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
		if (do_pop)
			rdata_q <= mem_q[rd_q];
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;
	assign empty  = (cnt_q == '0);
	assign level  = cnt_q;

endmodule
`default_nettype wire

@@ sv/cch_back.sv @@
`default_nettype none
module cch_back import cch_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire pair_t            item,
	input  wire logic [ANG_W-1:0] threshold,
	output logic                  done,
	output logic                  hit,
	output logic                  kinematics_valid,
	output logic      [ANG_W-1:0] compton_angle,
	output logic      [ANG_W-1:0] geometric_angle
);
	localparam int SQ_LAT   = LEN_W / 2;
	localparam int GQ_W     = 19;
	localparam int CQ_W     = 18;
	localparam int GEO_LAT  = SQ_LAT + 1 + GQ_W + 1;
	localparam int CC_DLY   = GEO_LAT - (CQ_W + 1);
	localparam int ACOS_LAT = SQ_LAT + CORDIC_STEPS + 3;
	localparam int TOTAL    = GEO_LAT + ACOS_LAT + 1;

	// geometric cosine path
	logic [ROOT_W-1:0]       ra, rb;
	logic [DOT_W:0]          dg_q [SQ_LAT];
	logic signed [DOT_W-1:0] dot_d;
	logic [DOT_W-1:0]        mag;
	logic [LEN_W-1:0]        prod_q, mag_q;
	logic                    neg_q, nz_q;
	logic [GQ_W-1:0]         qg;
	logic [1:0]              dn_q [GQ_W];
	logic [ROOT_W-1:0]       qcl;
	logic signed [COS_W-1:0] gcn;
	logic signed [COS_W-1:0] gc_q;

	// compton cosine path
	logic [CQ_W-1:0]         qc;
	logic                    ok_q [CQ_W];
	logic signed [COS_W-1:0] cc_q;
	logic                    ccok_q;
	logic [COS_W:0]          cd_q [CC_DLY];

	logic [ANG_W-1:0] ga, ca, diff;
	logic             ao_q [ACOS_LAT];
	logic             okf;
	logic             vl_q [TOTAL];
	logic             hit_q, kv_q;
	logic [ANG_W-1:0] comp_q, geo_q;

	cch_sqrt #(.W(LEN_W)) u_sqrt_a (.clk(clk), .rad(item.la), .root(ra));
	cch_sqrt #(.W(LEN_W)) u_sqrt_b (.clk(clk), .rad(item.lb), .root(rb));

	assign dot_d = dg_q[SQ_LAT-1][DOT_W-1:0];
	assign mag   = dot_d[DOT_W-1] ? DOT_W'(-dot_d) : DOT_W'(dot_d);

	always_ff @(posedge clk) begin
		dg_q[0] <= {(item.la != '0) && (item.lb != '0), item.dot};
		for (int i = 1; i < SQ_LAT; i++) dg_q[i] <= dg_q[i-1];
		prod_q <= LEN_W'(ra) * LEN_W'(rb);
		mag_q  <= mag[LEN_W-1:0];
		neg_q  <= dot_d[DOT_W-1];
		nz_q   <= dg_q[SQ_LAT-1][DOT_W];
	end

	cch_div #(.NW(LEN_W + 16), .DW(LEN_W), .QW(GQ_W)) u_div_geo (
		.clk (clk),
		.num ({mag_q, 16'b0}),
		.den (prod_q),
		.quo (qg)
	);

	assign qcl = (qg > GQ_W'(COS_ONE)) ? ROOT_W'(COS_ONE) : qg[ROOT_W-1:0];
	assign gcn = signed'({1'b0, qcl});

	// zero-length vector gives cosine 0
	always_ff @(posedge clk) begin
		dn_q[0] <= {nz_q, neg_q};
		for (int i = 1; i < GQ_W; i++) dn_q[i] <= dn_q[i-1];
		if (!dn_q[GQ_W-1][1])
			gc_q <= '0;
		else if (dn_q[GQ_W-1][0])
			gc_q <= -gcn;
		else
			gc_q <= gcn;
	end

	cch_div #(.NW(NUM_W + 16), .DW(DEN_W), .QW(CQ_W)) u_div_cmp (
		.clk (clk),
		.num ({item.num, 16'b0}),
		.den (item.den),
		.quo (qc)
	);

	always_ff @(posedge clk) begin
		ok_q[0] <= item.kin_ok;
		for (int i = 1; i < CQ_W; i++) ok_q[i] <= ok_q[i-1];
		cc_q   <= COS_W'((COS_W+1)'(COS_ONE) - (COS_W+1)'(qc));
		ccok_q <= ok_q[CQ_W-1];
		cd_q[0] <= {ccok_q, cc_q};
		for (int i = 1; i < CC_DLY; i++) cd_q[i] <= cd_q[i-1];
	end

	cch_acos #(.STEPS(CORDIC_STEPS)) u_acos_geo (
		.clk   (clk),
		.c     (gc_q),
		.angle (ga)
	);

	cch_acos #(.STEPS(CORDIC_STEPS)) u_acos_cmp (
		.clk   (clk),
		.c     (signed'(cd_q[CC_DLY-1][COS_W-1:0])),
		.angle (ca)
	);

	assign okf  = ao_q[ACOS_LAT-1];
	assign diff = (ga > ca) ? ga - ca : ca - ga;

	always_ff @(posedge clk) begin
		ao_q[0] <= cd_q[CC_DLY-1][COS_W];
		for (int i = 1; i < ACOS_LAT; i++) ao_q[i] <= ao_q[i-1];
		hit_q  <= okf && (diff < threshold);
		kv_q   <= okf;
		comp_q <= okf ? ca : '0;
		geo_q  <= ga;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL; i++) vl_q[i] <= 1'b0;
		end else begin
			vl_q[0] <= in_valid;
			for (int i = 1; i < TOTAL; i++) vl_q[i] <= vl_q[i-1];
		end
	end

	assign done             = vl_q[TOTAL-1];
	assign hit              = hit_q;
	assign kinematics_valid = kv_q;
	assign compton_angle    = comp_q;
	assign geometric_angle  = geo_q;

endmodule
`default_nettype wire

@@ sv/compton_cone_hit_test.sv @@
`default_nettype none
// compton cone hit test: one event (scatter and absorber hits with energies)
// paired with one voxel per transaction.
// input: a transaction is taken at a clock edge with start high and busy low;
// a new transaction may follow every cycle. busy rises only when the queue
// between the front and back sections nears full, which does not happen in
// steady streaming since the back section never stalls.
// output: done is high for exactly one cycle with hit, kinematics_valid,
// compton_angle and geometric_angle; the receiver cannot hold results off.
// from accept to done: 3 front stages, 1 queue write, 1 queue read,
// 17 square root stages, 1 multiply, 19 divide stages, 1 cosine stage,
// CORDIC_STEPS + 20 arc cosine stages, 1 compare stage. throughput is one
// transaction per cycle while busy is low. angle_threshold is written
// through the apb port at byte address 0; the user must write it only while
// the block is idle, which the block itself does not enforce. reset clears
// the valid pipeline, the queue pointers and sets the threshold to 80.
module compton_cone_hit_test import cch_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] scatter_x,
	input  wire logic signed [15:0] scatter_y,
	input  wire logic signed [15:0] scatter_z,
	input  wire logic        [12:0] scatter_energy,
	input  wire logic signed [15:0] absorber_x,
	input  wire logic signed [15:0] absorber_y,
	input  wire logic signed [15:0] absorber_z,
	input  wire logic        [12:0] absorber_energy,
	input  wire logic signed [15:0] voxel_x,
	input  wire logic signed [15:0] voxel_y,
	input  wire logic signed [15:0] voxel_z,
	output logic                    done,
	output logic                    hit,
	output logic                    kinematics_valid,
	output logic        [ANG_W-1:0] compton_angle,
	output logic        [ANG_W-1:0] geometric_angle,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [2:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready
);
	logic             accept;
	logic             push, empty, q_valid;
	logic [QUEUE_AW:0] level;
	pair_t            f_item, q_item;
	logic [ANG_W-1:0] thr_q;

	assign accept = start && !busy;
	assign busy   = level >= (QUEUE_AW+1)'(BUSY_LEVEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THRESHOLD_RESET;
		else if (psel && penable && pwrite && (paddr[2] == IDX_THRESHOLD))
			thr_q <= pwdata[ANG_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == IDX_THRESHOLD) ? {20'b0, thr_q} : 32'b0;

	cch_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.scatter_x       (scatter_x),
		.scatter_y       (scatter_y),
		.scatter_z       (scatter_z),
		.scatter_energy  (scatter_energy),
		.absorber_x      (absorber_x),
		.absorber_y      (absorber_y),
		.absorber_z      (absorber_z),
		.absorber_energy (absorber_energy),
		.voxel_x         (voxel_x),
		.voxel_y         (voxel_y),
		.voxel_z         (voxel_z),
		.push            (push),
		.item            (f_item)
	);

	cch_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.pop    (!empty),
		.rdata  (q_item),
		.rvalid (q_valid),
		.empty  (empty),
		.level  (level)
	);

	cch_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (q_valid),
		.item             (q_item),
		.threshold        (thr_q),
		.done             (done),
		.hit              (hit),
		.kinematics_valid (kinematics_valid),
		.compton_angle    (compton_angle),
		.geometric_angle  (geometric_angle)
	);

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
	import cch_pkg::*;

	localparam int LATENCY = 80;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] sx, sy, sz;
		logic        [12:0] se;
		logic signed [15:0] ax, ay, az;
		logic        [12:0] ae;
		logic signed [15:0] vx, vy, vz;
	} pair_in_t;

	typedef struct packed {
		logic             hit;
		logic             kin_valid;
		logic [ANG_W-1:0] comp_ang;
		logic [ANG_W-1:0] geo_ang;
	} cone_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] scatter_x = '0, scatter_y = '0, scatter_z = '0;
	logic [12:0] scatter_energy = '0, absorber_energy = '0;
	logic signed [15:0] absorber_x = '0, absorber_y = '0, absorber_z = '0;
	logic signed [15:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
	logic done, hit, kinematics_valid;
	logic [ANG_W-1:0] compton_angle, geometric_angle;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	compton_cone_hit_test i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.scatter_x(scatter_x), .scatter_y(scatter_y), .scatter_z(scatter_z),
		.scatter_energy(scatter_energy),
		.absorber_x(absorber_x), .absorber_y(absorber_y), .absorber_z(absorber_z),
		.absorber_energy(absorber_energy),
		.voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
		.done(done), .hit(hit), .kinematics_valid(kinematics_valid),
		.compton_angle(compton_angle), .geometric_angle(geometric_angle),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	pair_in_t  pending_pairs[$];
	cone_res_t expected_cones[$];
	logic [11:0] threshold = THRESHOLD_RESET;
	logic stream_solid = 1'b0;
	int cycle_cnt = 0;
	int fail_cnt = 0;
	int pair_cnt = 0;
	int hit_cnt = 0;
	int invalid_cnt = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// q16 cosine to angle in 1/16 degree via cordic vectoring
	function automatic logic [ANG_W-1:0] cos_to_angle(input longint c);
		longint cabs, x, y, z, dx, dy, t;
		longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117305,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		cabs = c < 0 ? -c : c;
		if (cabs > COS_ONE) cabs = COS_ONE;
		if (c < 0) begin
			x = longint'(int_sqrt(64'h1_0000_0000 - cabs * cabs));
			y = -c;
			z = 90 * 65536;
		end else begin
			x = c;
			y = longint'(int_sqrt(64'h1_0000_0000 - cabs * cabs));
			z = 0;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_deg[i];
			end else begin
				x -= dx; y += dy; z -= atan_deg[i];
			end
		end
		t = (z + 2048) >>> 12;
		if (t < 0) t = 0;
		if (t > 2880) t = 2880;
		return t[ANG_W-1:0];
	endfunction

	function automatic cone_res_t predict_cone(input pair_in_t p);
		cone_res_t r;
		longint a[3], b[3], dot, la, lb, gc, mag, q, e1, e2, den, num;
		a[0] = p.sx - p.vx; a[1] = p.sy - p.vy; a[2] = p.sz - p.vz;
		b[0] = p.ax - p.sx; b[1] = p.ay - p.sy; b[2] = p.az - p.sz;
		la = 0; lb = 0; dot = 0; gc = 0;
		for (int k = 0; k < 3; k++) begin
			la += a[k] * a[k];
			lb += b[k] * b[k];
			dot += a[k] * b[k];
		end
		if (la != 0 && lb != 0) begin
			mag = dot < 0 ? -dot : dot;
			q = (mag << 16) / longint'(int_sqrt(la) * int_sqrt(lb));
			if (q > COS_ONE) q = COS_ONE;
			gc = dot < 0 ? -q : q;
		end
		r = '0;
		r.geo_ang = cos_to_angle(gc);
		e1 = p.se;
		e2 = p.ae;
		if (e1 != 0 && e2 != 0) begin
			den = e2 * (e1 + e2);
			num = 511 * e1;
			if (num < 2 * den) begin
				r.kin_valid = 1'b1;
				r.comp_ang = cos_to_angle(65536 - (num << 16) / den);
			end
		end
		if (r.kin_valid)
			r.hit = ((r.geo_ang > r.comp_ang) ? r.geo_ang - r.comp_ang
				: r.comp_ang - r.geo_ang) < threshold;
		return r;
	endfunction

	// driver: one pending pair per accepted start
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_cones.push_back(predict_cone(pending_pairs.pop_front()));
			pair_cnt++;
		end
		if (pending_pairs.size() > 0 && (stream_solid || $urandom_range(99) >= 7)) begin
			start <= 1'b1;
			{scatter_x, scatter_y, scatter_z, scatter_energy, absorber_x, absorber_y,
				absorber_z, absorber_energy, voxel_x, voxel_y, voxel_z}
				<= (start && !busy) ? pending_pairs[0]
				: pending_pairs[0];
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cone_res_t want;
		if (done) begin
			if (expected_cones.size() == 0) begin
				$display("%0t: unexpected transaction hit=%0b valid=%0b comp=%0d geo=%0d",
					$time, hit, kinematics_valid, compton_angle, geometric_angle);
				fail_cnt++;
			end else begin
				want = expected_cones.pop_front();
				if (want.hit != hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
					fail_cnt++;
				end
				if (want.kin_valid != kinematics_valid) begin
					$display("%0t: kinematics_valid expected %0b actual %0b",
						$time, want.kin_valid, kinematics_valid);
					fail_cnt++;
				end
				if (want.comp_ang != compton_angle) begin
					$display("%0t: compton_angle expected %0d actual %0d",
						$time, want.comp_ang, compton_angle);
					fail_cnt++;
				end
				if (want.geo_ang != geometric_angle) begin
					$display("%0t: geometric_angle expected %0d actual %0d",
						$time, want.geo_ang, geometric_angle);
					fail_cnt++;
				end
				hit_cnt += hit;
				invalid_cnt += !kinematics_valid;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_cones.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_threshold(input logic [11:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'd0; pwdata <= {20'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold = value;
	endtask

	task automatic drain();
		while (pending_pairs.size() > 0 || expected_cones.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [12:0] rand_energy();
		case ($urandom_range(7))
			0: return 13'd0;
			1: return 13'h1fff;
			2: return 13'($urandom_range(1, 100));
			default: return 13'($urandom_range(50, 3000));
		endcase
	endfunction

	task automatic queue_pair(input logic signed [15:0] sx, sy, sz, input logic [12:0] se,
		input logic signed [15:0] ax, ay, az, input logic [12:0] ae,
		input logic signed [15:0] vx, vy, vz);
		pending_pairs.push_back({sx, sy, sz, se, ax, ay, az, ae, vx, vy, vz});
	endtask

	task automatic queue_random(input int n);
		pair_in_t p;
		logic signed [15:0] d;
		for (int i = 0; i < n; i++) begin
			p = {rand_coord(), rand_coord(), rand_coord(), rand_energy(), rand_coord(),
				rand_coord(), rand_coord(), rand_energy(), rand_coord(), rand_coord(),
				rand_coord()};
			// a few zero-length vectors and voxel-on-axis pairs
			case ($urandom_range(15))
				0: {p.vx, p.vy, p.vz} = {p.sx, p.sy, p.sz};
				1: {p.ax, p.ay, p.az} = {p.sx, p.sy, p.sz};
				2: begin
					d = 16'(signed'($urandom_range(60)) - 30);
					p.vx = p.sx - d; p.ax = p.sx + d;
					p.vy = p.sy; p.ay = p.sy; p.vz = p.sz; p.az = p.sz;
				end
				default: ;
			endcase
			pending_pairs.push_back(p);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: energies, extremes, degenerate vectors
		queue_pair(0, 0, 0, 0, 10, 0, 0, 0, -10, 0, 0);
		queue_pair(0, 0, 0, 300, 10, 0, 0, 0, -10, 0, 0);
		queue_pair(0, 0, 0, 0, 10, 0, 0, 400, -10, 0, 0);
		queue_pair(0, 0, 0, 200, 10, 0, 0, 500, -10, 0, 0);
		queue_pair(0, 0, 0, 8191, 0, 10, 0, 8191, 10, 0, 0);
		queue_pair(0, 0, 0, 1, 0, 0, 10, 8191, 0, 0, -10);
		queue_pair(0, 0, 0, 8191, 0, 0, 10, 1, 0, 0, -10);
		queue_pair(0, 0, 0, 100, 0, 0, 0, 100, 5, 5, 5);
		queue_pair(3, 3, 3, 100, 9, 9, 9, 100, 3, 3, 3);
		queue_pair(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0);
		queue_pair(32767, 32767, 32767, 662, -32768, -32768, -32768, 662,
			-32768, -32768, -32768);
		queue_pair(-32768, -32768, -32768, 4000, 32767, 32767, 32767, 4000,
			32767, 32767, 32767);
		queue_pair(-32768, 32767, -32768, 150, 32767, -32768, 32767, 350,
			-32768, -32768, 32767);
		queue_pair(100, 0, 0, 300, 200, 0, 0, 662, 0, 0, 0);
		queue_pair(100, 0, 0, 300, 0, 0, 0, 662, 0, 0, 0);
		queue_pair(0, 0, 0, 255, 0, 0, 100, 256, 100, 0, 0);
		queue_pair(-1, -1, -1, 5000, 1, 1, 1, 5000, -2, -2, -2);
		drain();

		write_threshold(12'd0);
		queue_random(250);
		drain();
		write_threshold(12'd4095);
		queue_random(200);
		drain();
		write_threshold(12'd2880);
		stream_solid = 1'b1;
		queue_random(250);
		drain();
		stream_solid = 1'b0;
		write_threshold(12'($urandom_range(1, 400)));
		queue_random(300);
		drain();
		write_threshold(THRESHOLD_RESET);
		queue_random(250);
		drain();

		$display("%0d event-voxel pairs checked, %0d hits, %0d kinematically invalid",
			pair_cnt, hit_cnt, invalid_cnt);
		$display("thresholds 0, 4095, 2880, random and 80; bursts and random gaps");
		if (fail_cnt == 0 && expected_cones.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
